FILE: sv/dpvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dpvc_pkg;

   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int TIME_W   = 16;
   localparam int MUL_BITS = 20;
   localparam int DER_W    = 32;
   localparam int QUOT_W   = DER_W + 1;
   localparam int ACC_W    = 49;
   localparam int RND_W    = ACC_W - 8;
   localparam int CNT_W    = 6;

   localparam logic [MUL_BITS-1:0] MILLION = 20'd1000000;
   localparam logic [TIME_W-1:0]   T_ZERO  = 16'd1000;

   localparam logic signed [DER_W-1:0] DER_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DER_W-1:0] DER_MIN = 32'sh8000_0000;
   localparam logic [QUOT_W-1:0]       NEG_CAP = 33'h0_8000_0000;

   localparam logic signed [GAIN_W-1:0] KP_RESET  = 16'sd512;
   localparam logic signed [GAIN_W-1:0] KD_RESET  = 16'sd26;
   localparam logic [LIMIT_W-1:0]       LIN_RESET = 15'd1229;
   localparam logic [LIMIT_W-1:0]       ANG_RESET = 15'd4096;

   typedef enum logic [1:0] {
      REG_KP      = 2'd0,
      REG_KD      = 2'd1,
      REG_LIN_LIM = 2'd2,
      REG_ANG_LIM = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_SAT,
      ST_SUM,
      ST_MAC,
      ST_RND,
      ST_DONE
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] cnt;
      logic             start;
   } ctrl_type;

endpackage
`default_nettype wire

FILE: sv/dual_pd_velocity_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Two PD channels (linear from forward error, angular from lateral error) sharing one pair
// of Q8.8 gains, each derivative being the error delta times 1e6 over the elapsed time
// (0 us taken as 1000 us), each command rounded to Q4.12 and clamped to its own limit.
// One item is worked on at a time: an item with a valid plan passes through a serial
// multiply of the delta magnitude by 1e6 over the 20 bits of that constant, then a
// bit-serial restoring divide that gives one quotient bit per cycle over the numerator's
// DATA_WIDTH + 20 bits, then a serial pass over the 16 gain bits; an item with plan_valid
// low skips these steps and is answered with zero commands.
// A finished result waits in the output register while the next item is accepted.
module dual_pd_velocity_controller_core #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // forward_error, lateral_error, elapsed_us
   input  wire logic [((2*DATA_WIDTH+16+7)/8)*8-1:0]      req_tdata,
   // plan_valid
   input  wire logic                                      req_tuser,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // linear_cmd, angular_cmd
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]              rsp_tdata,
   input  wire logic                                      csr_we,
   input  wire logic [1:0]                                csr_addr,
   input  wire logic [dpvc_pkg::GAIN_W-1:0]               csr_wdata
);
   import dpvc_pkg::*;

   localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;

   logic signed [GAIN_W-1:0]     kp_ff, kp_in;
   logic signed [GAIN_W-1:0]     kd_ff, kd_in;
   logic [LIMIT_W-1:0]           lin_lim_ff, lin_lim_in;
   logic [LIMIT_W-1:0]           ang_lim_ff, ang_lim_in;
   logic signed [DATA_WIDTH-1:0] prev_fwd_ff, prev_fwd_in;
   logic signed [DATA_WIDTH-1:0] prev_lat_ff, prev_lat_in;
   logic                         plan_ff, plan_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]             rsp_data_ff, rsp_data_in;

   ctrl_type                     ctrl;
   logic                         accept;
   logic                         out_free;
   logic                         load;
   logic signed [DATA_WIDTH-1:0] fwd_err;
   logic signed [DATA_WIDTH-1:0] lat_err;
   logic [TIME_W-1:0]            elapsed;
   logic [TIME_W-1:0]            period;
   logic signed [DATA_WIDTH-1:0] lin_cmd;
   logic signed [DATA_WIDTH-1:0] ang_cmd;

   assign fwd_err  = req_tdata[DATA_WIDTH-1:0];
   assign lat_err  = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
   assign elapsed  = req_tdata[2*DATA_WIDTH+TIME_W-1:2*DATA_WIDTH];
   assign period   = (elapsed == '0) ? T_ZERO : elapsed;

   assign req_tready = ctrl.phase == ST_IDLE;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign load       = (ctrl.phase == ST_DONE) & out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   dpvc_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .plan_valid (req_tuser),
      .out_free   (out_free),
      .ctrl       (ctrl)
   );

   dpvc_lane #(.DATA_WIDTH(DATA_WIDTH)) u_lin (
      .clock  (clock),
      .ctrl   (ctrl),
      .err    (fwd_err),
      .prev   (prev_fwd_ff),
      .period (period),
      .kp     (kp_ff),
      .kd     (kd_ff),
      .limit  (lin_lim_ff),
      .cmd    (lin_cmd)
   );

   dpvc_lane #(.DATA_WIDTH(DATA_WIDTH)) u_ang (
      .clock  (clock),
      .ctrl   (ctrl),
      .err    (lat_err),
      .prev   (prev_lat_ff),
      .period (period),
      .kp     (kp_ff),
      .kd     (kd_ff),
      .limit  (ang_lim_ff),
      .cmd    (ang_cmd)
   );

   always_comb begin
      kp_in      = kp_ff;
      kd_in      = kd_ff;
      lin_lim_in = lin_lim_ff;
      ang_lim_in = ang_lim_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_KP:      kp_in      = csr_wdata;
            REG_KD:      kd_in      = csr_wdata;
            REG_LIN_LIM: lin_lim_in = csr_wdata[LIMIT_W-1:0];
            REG_ANG_LIM: ang_lim_in = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prev_fwd_in = prev_fwd_ff;
      prev_lat_in = prev_lat_ff;
      plan_in     = plan_ff;
      if (accept) begin
         plan_in = req_tuser;
         if (req_tuser) begin
            prev_fwd_in = fwd_err;
            prev_lat_in = lat_err;
         end
      end
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in = plan_ff ? OUT_W'({ang_cmd, lin_cmd}) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KP_RESET;
         kd_ff        <= KD_RESET;
         lin_lim_ff   <= LIN_RESET;
         ang_lim_ff   <= ANG_RESET;
         prev_fwd_ff  <= '0;
         prev_lat_ff  <= '0;
         plan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         lin_lim_ff   <= lin_lim_in;
         ang_lim_ff   <= ang_lim_in;
         prev_fwd_ff  <= prev_fwd_in;
         prev_lat_ff  <= prev_lat_in;
         plan_ff      <= plan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

FILE: sv/dpvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dpvc_ctrl #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              plan_valid,
   input  wire logic              out_free,
   output dpvc_pkg::ctrl_type     ctrl
);
   import dpvc_pkg::*;

   localparam int NW = DATA_WIDTH + MUL_BITS;

   phase_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = plan_valid ? ST_PREP : ST_DONE;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: state_in = ST_SUM;
         ST_SUM: state_in = ST_MAC;
         ST_MAC: begin
            if (cnt_ff == '0) begin
               state_in = ST_RND;
            end
         end
         ST_RND: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // bit counter for the serial phases
   always_comb begin
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_PREP: cnt_in = CNT_W'(MUL_BITS - 1);
         ST_MUL: begin
            cnt_in = (cnt_ff == '0) ? CNT_W'(NW - 1) : cnt_ff - 1'b1;
         end
         ST_DIV:  cnt_in = cnt_ff - 1'b1;
         ST_SUM:  cnt_in = CNT_W'(GAIN_W - 1);
         ST_MAC:  cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      ctrl.phase = state_ff;
      ctrl.cnt   = cnt_ff;
      ctrl.start = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/dpvc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module dpvc_lane #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire dpvc_pkg::ctrl_type                    ctrl,
   input  wire logic signed [DATA_WIDTH-1:0]          err,
   input  wire logic signed [DATA_WIDTH-1:0]          prev,
   input  wire logic [dpvc_pkg::TIME_W-1:0]           period,
   input  wire logic signed [dpvc_pkg::GAIN_W-1:0]    kp,
   input  wire logic signed [dpvc_pkg::GAIN_W-1:0]    kd,
   input  wire logic [dpvc_pkg::LIMIT_W-1:0]          limit,
   output logic signed [DATA_WIDTH-1:0]               cmd
);
   import dpvc_pkg::*;

   localparam int NW = DATA_WIDTH + MUL_BITS;

   logic signed [DATA_WIDTH-1:0] e_ff, e_in;
   logic signed [DATA_WIDTH:0]   d_ff, d_in;
   logic [TIME_W-1:0]            t_ff, t_in;
   logic [DATA_WIDTH-1:0]        mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [NW-1:0]                num_ff, num_in;
   logic [TIME_W-1:0]            rem_ff, rem_in;
   logic [QUOT_W-1:0]            quot_ff, quot_in;
   logic                         ovf_ff, ovf_in;
   logic signed [DER_W-1:0]      der_ff, der_in;
   logic signed [ACC_W-1:0]      epd_ff, epd_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [RND_W-1:0]      rnd_ff, rnd_in;

   logic [TIME_W:0]         rem_sh;
   logic [TIME_W:0]         rem_dif;
   logic                    fits;
   logic                    cap;
   logic signed [DATA_WIDTH:0] d_abs;
   logic signed [ACC_W-1:0] e_x;
   logic signed [ACC_W-1:0] der_x;
   logic signed [ACC_W-1:0] sel;
   logic signed [ACC_W-1:0] acc_sh;
   logic signed [ACC_W-1:0] acc_rnd;
   logic [3:0]              gi;
   logic signed [RND_W-1:0] lim_x;
   logic signed [RND_W-1:0] neg_lim;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NW-1]};
      fits    = rem_sh >= {1'b0, t_ff};
      rem_dif = rem_sh - {1'b0, t_ff};
      d_abs   = d_ff[DATA_WIDTH] ? -d_ff : d_ff;
      cap     = ovf_ff | (neg_ff ? (quot_ff > NEG_CAP) : (quot_ff[QUOT_W-1] | quot_ff[DER_W-1]));
      e_x     = {{(ACC_W - DATA_WIDTH){e_ff[DATA_WIDTH-1]}}, e_ff};
      der_x   = {{(ACC_W - DER_W){der_ff[DER_W-1]}}, der_ff};
      gi      = ctrl.cnt[3:0];
      case ({kp[gi], kd[gi]})
         2'b10:   sel = e_x;
         2'b01:   sel = der_x;
         2'b11:   sel = epd_ff;
         default: sel = '0;
      endcase
      acc_sh  = acc_ff <<< 1;
      acc_rnd = acc_ff + ACC_W'(128);
      lim_x   = {{(RND_W - LIMIT_W){1'b0}}, limit};
      neg_lim = -lim_x;
   end

   always_comb begin
      e_in    = e_ff;
      d_in    = d_ff;
      t_in    = t_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      der_in  = der_ff;
      epd_in  = epd_ff;
      acc_in  = acc_ff;
      rnd_in  = rnd_ff;
      if (ctrl.start) begin
         e_in = err;
         d_in = {err[DATA_WIDTH-1], err} - {prev[DATA_WIDTH-1], prev};
         t_in = period;
      end
      case (ctrl.phase)
         ST_PREP: begin
            mag_in  = d_abs[DATA_WIDTH-1:0];
            neg_in  = d_ff[DATA_WIDTH];
            num_in  = '0;
            rem_in  = '0;
            quot_in = '0;
            ovf_in  = 1'b0;
         end
         // delta magnitude times one million, msb first
         ST_MUL: begin
            num_in = (num_ff << 1)
                   + (MILLION[ctrl.cnt[4:0]] ? {{MUL_BITS{1'b0}}, mag_ff} : '0);
         end
         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            num_in  = num_ff << 1;
            rem_in  = fits ? rem_dif[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], fits};
            ovf_in  = ovf_ff | quot_ff[QUOT_W-1];
         end
         ST_SAT: begin
            if (neg_ff) begin
               der_in = cap ? DER_MIN : (~quot_ff[DER_W-1:0]) + 32'd1;
            end else begin
               der_in = cap ? DER_MAX : quot_ff[DER_W-1:0];
            end
         end
         ST_SUM: begin
            epd_in = e_x + der_x;
            acc_in = '0;
         end
         // both gains, one bit per cycle, sign bit first
         ST_MAC: begin
            acc_in = (ctrl.cnt == CNT_W'(GAIN_W - 1)) ? acc_sh - sel : acc_sh + sel;
         end
         ST_RND: begin
            rnd_in = acc_rnd[ACC_W-1:8];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (rnd_ff > lim_x) begin
         cmd = lim_x[DATA_WIDTH-1:0];
      end else if (rnd_ff < neg_lim) begin
         cmd = neg_lim[DATA_WIDTH-1:0];
      end else begin
         cmd = rnd_ff[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      d_ff    <= d_in;
      t_ff    <= t_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      der_ff  <= der_in;
      epd_ff  <= epd_in;
      acc_ff  <= acc_in;
      rnd_ff  <= rnd_in;
   end

endmodule
`default_nettype wire

FILE: sv/dpvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dpvc_checker #(
   parameter int DATA_WIDTH = 16
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic                                 req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp item changed while stalled");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req item accepted while busy");

   // an item without a plan, accepted with no result pending, gives a zero item after the done state
   a_no_plan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && !rsp_tvalid)
      |=> ##1 (rsp_tvalid && rsp_tdata[2*DATA_WIDTH-1:0] == '0))
      else $error("no-plan item not zero");

   // a new result appears only as the block goes idle
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("rsp item without returning idle");

   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

endmodule

bind dual_pd_velocity_controller_core dpvc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
